// ----- design/ppc_pkg.sv -----
// Shared types and constants for the polygon plane clipper.
// Holds the stored vertex record, class and status codes, controller states,
// and the command and status bundles between controller and datapath.
package ppc_pkg;

  localparam int COORD_W      = 32;
  localparam int DIST_W       = 40;
  localparam int TOL_W        = 16;
  localparam int RES_W        = 6;
  localparam int RESULT_LIMIT = 32;

  localparam logic [TOL_W-1:0] TOL_RESET = 16'd655;

  // Vertex classes against the plane.
  localparam logic [1:0] CLS_ON    = 2'd0;
  localparam logic [1:0] CLS_FRONT = 2'd1;
  localparam logic [1:0] CLS_BACK  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_CLIPPED  = 2'd0;
  localparam logic [1:0] ST_WHOLE    = 2'd1;
  localparam logic [1:0] ST_DISCARD  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  // Coordinate selects for the shared multiplier and the cut unit.
  localparam logic [1:0] SEL_X = 2'd0;
  localparam logic [1:0] SEL_Y = 2'd1;
  localparam logic [1:0] SEL_Z = 2'd2;

  // One stored vertex: coordinates, signed distance and class.
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic signed [DIST_W-1:0]  distance;
    logic [1:0]                cls;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_OVF,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_ACC,
    S_STORE,
    S_FINAL,
    S_SINGLE,
    S_CLEAR,
    S_RD0,
    S_RD0W,
    S_RDN,
    S_RDNW,
    S_EV,
    S_CG,
    S_CW,
    S_EC,
    S_ADV
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       accept;
    logic       set_ovf;
    logic       acc_init;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       acc_add;
    logic       store;
    logic       rd_first;
    logic       load_first;
    logic       rd_next;
    logic       load_next;
    logic       emit_vertex;
    logic       cut_start;
    logic       cut_save;
    logic       emit_cut;
    logic       emit_single;
    logic       advance;
    logic       clear;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
    logic count_full;
    logic single;
    logic out_free;
    logic emit_v;
    logic edge_cut;
    logic wrap;
    logic cut_done;
    logic cut_last;
  } status_t;

  // True when the edge from class a to class b joins the kept and removed sides.
  function automatic logic crosses(input logic [1:0] a, input logic [1:0] b,
                                   input logic keep);
    logic [1:0] kept_cls;
    logic [1:0] rem_cls;
    kept_cls = keep ? CLS_FRONT : CLS_BACK;
    rem_cls  = keep ? CLS_BACK : CLS_FRONT;
    return ((a == kept_cls) && (b == rem_cls)) || ((a == rem_cls) && (b == kept_cls));
  endfunction

endpackage

// ----- design/ppc_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module ppc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/ppc_cut_unit.sv -----
// Edge intersection unit: o + (p2 - o) * num / (num - dj) for one coordinate.
// Split multiply, low half then high half, then a restoring divide one bit per cycle.
// Depends on ppc_pkg.
module ppc_cut_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [ppc_pkg::COORD_W-1:0] o,
  input  logic signed [ppc_pkg::COORD_W-1:0] p2,
  input  logic signed [ppc_pkg::DIST_W-1:0]  num,
  input  logic signed [ppc_pkg::DIST_W-1:0]  dj,
  output logic                              done,
  output logic signed [ppc_pkg::COORD_W-1:0] result
);

  localparam int AD_W   = ppc_pkg::COORD_W + 1;
  localparam int AN_W   = ppc_pkg::DIST_W;
  localparam int HALF_W = AN_W / 2;
  localparam int DV_W   = ppc_pkg::DIST_W + 1;
  localparam int PROD_W = AD_W + AN_W;
  localparam int CYC_W  = 7;
  localparam logic [CYC_W-1:0] CYC_LAST = CYC_W'(PROD_W + 1);

  logic                     busy;
  logic [CYC_W-1:0]         cyc;
  logic [AD_W-1:0]          ad;
  logic [AN_W-1:0]          an;
  logic [DV_W-1:0]          dv;
  logic signed [ppc_pkg::COORD_W-1:0] o_reg;
  logic                     neg;
  logic [AD_W+HALF_W-1:0]   plo;
  logic [PROD_W-1:0]        dvd;
  logic [DV_W-1:0]          rem;
  logic [ppc_pkg::COORD_W-1:0] quo;

  logic signed [AD_W-1:0]   delta;
  logic signed [DV_W-1:0]   den;
  logic [DV_W:0]            rem_sh;

  // Signed differences for the start registers, and the shifted remainder.
  assign delta  = AD_W'(p2) - AD_W'(o);
  assign den    = DV_W'(num) - DV_W'(dj);
  assign rem_sh = {rem, dvd[PROD_W-1]};

  // Sequencing counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cyc  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cyc  <= '0;
      end else if (busy) begin
        cyc <= cyc + CYC_W'(1);
        if (cyc == CYC_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Multiply and divide datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      ad    <= delta[AD_W-1] ? AD_W'(-delta) : AD_W'(delta);
      neg   <= delta[AD_W-1];
      an    <= num[AN_W-1] ? AN_W'(-num) : AN_W'(num);
      dv    <= den[DV_W-1] ? DV_W'(-den) : DV_W'(den);
      o_reg <= o;
    end else if (busy) begin
      if (cyc == CYC_W'(0)) begin
        plo <= (AD_W+HALF_W)'(ad * an[HALF_W-1:0]);
      end else if (cyc == CYC_W'(1)) begin
        dvd <= PROD_W'(plo) + (PROD_W'(ad * an[AN_W-1:HALF_W]) << HALF_W);
        rem <= '0;
        quo <= '0;
      end else begin
        dvd <= dvd << 1;
        if (rem_sh >= (DV_W+1)'(dv)) begin
          rem <= DV_W'(rem_sh - (DV_W+1)'(dv));
          quo <= {quo[ppc_pkg::COORD_W-2:0], 1'b1};
        end else begin
          rem <= DV_W'(rem_sh);
          quo <= {quo[ppc_pkg::COORD_W-2:0], 1'b0};
        end
      end
    end
  end

  // The result is o moved by the quotient magnitude in the direction of p2 - o.
  assign result = neg ? (o_reg - $signed(quo)) : (o_reg + $signed(quo));

endmodule

// ----- design/ppc_datapath.sv -----
// Datapath of the clipper: distance unit, vertex store, edge walk registers,
// cut unit and the output register. Depends on ppc_pkg, ppc_ram, ppc_cut_unit.
module ppc_datapath #(
  parameter int MAX_VERTICES = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ppc_pkg::TOL_W-1:0]           cfg_wdata,
  input  logic signed [ppc_pkg::COORD_W-1:0]  vertex_x,
  input  logic signed [ppc_pkg::COORD_W-1:0]  vertex_y,
  input  logic signed [ppc_pkg::COORD_W-1:0]  vertex_z,
  input  logic signed [31:0]                  normal_x,
  input  logic signed [31:0]                  normal_y,
  input  logic signed [31:0]                  normal_z,
  input  logic signed [ppc_pkg::COORD_W-1:0]  plane_offset,
  input  logic                                keep_front,
  input  logic                                last_vertex,
  input  ppc_pkg::cmd_t                       cmd,
  output ppc_pkg::status_t                    status,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [1:0]                          clip_status,
  output logic signed [ppc_pkg::COORD_W-1:0]  out_x,
  output logic signed [ppc_pkg::COORD_W-1:0]  out_y,
  output logic signed [ppc_pkg::COORD_W-1:0]  out_z,
  output logic                                is_cut_point,
  output logic                                last_result
);

  localparam int CW  = $clog2(MAX_VERTICES + 1);
  localparam int AW  = $clog2(MAX_VERTICES);
  localparam int RW  = $clog2(2 * MAX_VERTICES + 1);
  localparam int PW  = 34;
  localparam int DW  = ppc_pkg::DIST_W;
  localparam int EW  = $bits(ppc_pkg::entry_t);

  logic [ppc_pkg::TOL_W-1:0] tol;
  logic signed [31:0] v_x, v_y, v_z;
  logic signed [31:0] n_x, n_y, n_z, p_off;
  logic               keep;
  logic               last_reg;
  logic signed [PW-1:0] prod;
  logic signed [DW-1:0] acc;
  logic [CW-1:0]      count;
  logic               ovf;
  logic               seen_rem;
  logic               seen_kept;
  logic [1:0]         first_cls;
  logic [1:0]         prev_cls;
  logic [RW-1:0]      res_acc;
  logic [AW-1:0]      idx;
  logic [ppc_pkg::RES_W-1:0] emit_cnt;
  logic [1:0]         cut_sel;
  logic signed [31:0] cut_x, cut_y, cut_z;
  ppc_pkg::entry_t    cur, nxt, first;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod_full;
  logic [1:0]         new_cls;
  logic [1:0]         kept_cls, rem_cls;
  logic signed [DW-1:0] tol_ext;
  ppc_pkg::entry_t    wentry;
  logic [EW-1:0]      rdata;
  ppc_pkg::entry_t    rentry;
  logic [AW-1:0]      raddr;
  logic               whole;
  logic               wrap;
  logic [7:0]         sum8;
  logic [ppc_pkg::RES_W-1:0] capped;
  logic [ppc_pkg::RES_W-1:0] total;
  logic               room;
  logic               out_last;
  logic               cut_done;
  logic signed [31:0] cut_res;
  logic signed [31:0] cut_o, cut_p2;
  logic               load_v, load_c;

  // Tolerance register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= ppc_pkg::TOL_RESET;
    end else if (cfg_we) begin
      tol <= cfg_wdata;
    end
  end

  // Side decode and classification of the finished distance.
  assign kept_cls = keep ? ppc_pkg::CLS_FRONT : ppc_pkg::CLS_BACK;
  assign rem_cls  = keep ? ppc_pkg::CLS_BACK : ppc_pkg::CLS_FRONT;
  assign tol_ext  = $signed(DW'(tol));

  always_comb begin
    if (acc > tol_ext) begin
      new_cls = ppc_pkg::CLS_FRONT;
    end else if (acc < -tol_ext) begin
      new_cls = ppc_pkg::CLS_BACK;
    end else begin
      new_cls = ppc_pkg::CLS_ON;
    end
  end

  // Shared multiplier for the three normal terms.
  always_comb begin
    case (cmd.mul_sel)
      ppc_pkg::SEL_X: begin
        mul_a = n_x;
        mul_b = v_x;
      end
      ppc_pkg::SEL_Y: begin
        mul_a = n_y;
        mul_b = v_y;
      end
      default: begin
        mul_a = n_z;
        mul_b = v_z;
      end
    endcase
  end
  assign prod_full = mul_a * mul_b;

  // Input capture, product and accumulator registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      v_x      <= vertex_x;
      v_y      <= vertex_y;
      v_z      <= vertex_z;
      last_reg <= last_vertex;
    end
    if (cmd.mul_en) begin
      prod <= prod_full[63:30];
    end
    if (cmd.acc_init) begin
      acc <= -(DW'(p_off));
    end else if (cmd.acc_add) begin
      acc <= acc + DW'(prod);
    end
  end

  // Stored vertex record.
  assign wentry.x        = v_x;
  assign wentry.y        = v_y;
  assign wentry.z        = v_z;
  assign wentry.distance = acc;
  assign wentry.cls      = new_cls;

  assign raddr  = cmd.rd_first ? '0 : (idx + AW'(1));
  assign rentry = ppc_pkg::entry_t'(rdata);

  ppc_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_VERTICES)
  ) u_store (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (count[AW-1:0]),
    .wdata (EW'(wentry)),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Polygon control state: plane, counts and side flags.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count     <= '0;
      ovf       <= 1'b0;
      seen_rem  <= 1'b0;
      seen_kept <= 1'b0;
      res_acc   <= '0;
      keep      <= 1'b0;
      n_x       <= '0;
      n_y       <= '0;
      n_z       <= '0;
      p_off     <= '0;
      first_cls <= ppc_pkg::CLS_ON;
      prev_cls  <= ppc_pkg::CLS_ON;
    end else begin
      if (cmd.accept && (count == '0) && !ovf) begin
        n_x   <= normal_x;
        n_y   <= normal_y;
        n_z   <= normal_z;
        p_off <= plane_offset;
        keep  <= keep_front;
      end
      if (cmd.set_ovf) begin
        ovf <= 1'b1;
      end
      if (cmd.store) begin
        count <= count + CW'(1);
        if (new_cls == kept_cls) begin
          seen_kept <= 1'b1;
        end else if (new_cls != ppc_pkg::CLS_ON) begin
          seen_rem <= 1'b1;
        end
        if (count == '0) begin
          first_cls <= new_cls;
        end
        prev_cls <= new_cls;
        res_acc  <= res_acc + RW'(new_cls != rem_cls)
                  + RW'((count != '0) && ppc_pkg::crosses(prev_cls, new_cls, keep));
      end
    end
  end

  // Result count: whole polygon, or kept vertices plus cut edges, capped.
  assign whole  = !seen_rem;
  assign sum8   = 8'(res_acc) + 8'(ppc_pkg::crosses(prev_cls, first_cls, keep));
  assign capped = (sum8 > 8'(ppc_pkg::RESULT_LIMIT)) ? ppc_pkg::RES_W'(ppc_pkg::RESULT_LIMIT)
                                                      : ppc_pkg::RES_W'(sum8);
  assign total    = whole ? ppc_pkg::RES_W'(count) : capped;
  assign room     = emit_cnt < total;
  assign out_last = emit_cnt == (total - ppc_pkg::RES_W'(1));
  assign wrap     = (CW'(idx) + CW'(1)) == count;

  // Edge walk registers.
  always_ff @(posedge clk) begin
    if (cmd.load_first) begin
      first <= rentry;
      cur   <= rentry;
    end
    if (cmd.load_next) begin
      nxt <= wrap ? first : rentry;
    end
    if (cmd.advance) begin
      cur <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      idx      <= '0;
      emit_cnt <= '0;
      cut_sel  <= ppc_pkg::SEL_X;
    end else begin
      if (cmd.load_first) begin
        idx <= '0;
      end else if (cmd.advance) begin
        idx <= idx + AW'(1);
      end
      if (load_v || load_c) begin
        emit_cnt <= emit_cnt + ppc_pkg::RES_W'(1);
      end
      if (cmd.cut_save) begin
        cut_sel <= cut_sel + 2'd1;
      end else if (cmd.emit_cut) begin
        cut_sel <= ppc_pkg::SEL_X;
      end
    end
  end

  // Cut unit operand selection and result capture.
  always_comb begin
    case (cut_sel)
      ppc_pkg::SEL_X: begin
        cut_o  = cur.x;
        cut_p2 = nxt.x;
      end
      ppc_pkg::SEL_Y: begin
        cut_o  = cur.y;
        cut_p2 = nxt.y;
      end
      default: begin
        cut_o  = cur.z;
        cut_p2 = nxt.z;
      end
    endcase
  end

  ppc_cut_unit u_cut (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.cut_start),
    .o      (cut_o),
    .p2     (cut_p2),
    .num    (cur.distance),
    .dj     (nxt.distance),
    .done   (cut_done),
    .result (cut_res)
  );

  always_ff @(posedge clk) begin
    if (cmd.cut_save) begin
      case (cut_sel)
        ppc_pkg::SEL_X: cut_x <= cut_res;
        ppc_pkg::SEL_Y: cut_y <= cut_res;
        default:        cut_z <= cut_res;
      endcase
    end
  end

  // Output register.
  assign load_v = cmd.emit_vertex && room;
  assign load_c = cmd.emit_cut && room;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_v || load_c || cmd.emit_single) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_single) begin
      clip_status  <= ovf ? ppc_pkg::ST_OVERFLOW : ppc_pkg::ST_DISCARD;
      out_x        <= '0;
      out_y        <= '0;
      out_z        <= '0;
      is_cut_point <= 1'b0;
      last_result  <= 1'b1;
    end else if (load_v) begin
      clip_status  <= whole ? ppc_pkg::ST_WHOLE : ppc_pkg::ST_CLIPPED;
      out_x        <= cur.x;
      out_y        <= cur.y;
      out_z        <= cur.z;
      is_cut_point <= 1'b0;
      last_result  <= out_last;
    end else if (load_c) begin
      clip_status  <= ppc_pkg::ST_CLIPPED;
      out_x        <= cut_x;
      out_y        <= cut_y;
      out_z        <= cut_z;
      is_cut_point <= 1'b1;
      last_result  <= out_last;
    end
  end

  // Status toward the controller.
  assign status.last       = last_reg;
  assign status.count_full = count >= CW'(MAX_VERTICES);
  assign status.single     = ovf || (seen_rem && !seen_kept);
  assign status.out_free   = !out_valid || out_ready;
  assign status.emit_v     = whole || (cur.cls != rem_cls);
  assign status.edge_cut   = !whole && ppc_pkg::crosses(cur.cls, nxt.cls, keep);
  assign status.wrap       = wrap;
  assign status.cut_done   = cut_done;
  assign status.cut_last   = cut_sel == ppc_pkg::SEL_Z;

endmodule

// ----- design/ppc_ctrl.sv -----
// Controller of the clipper: sequences vertex load, the emit decision and
// the edge walk. Depends on ppc_pkg.
module ppc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ppc_pkg::status_t  status,
  output ppc_pkg::cmd_t     cmd
);

  ppc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ppc_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = status.count_full ? ppc_pkg::S_OVF : ppc_pkg::S_MUL0;
        end
      end
      ppc_pkg::S_OVF:   state_next = status.last ? ppc_pkg::S_FINAL : ppc_pkg::S_IDLE;
      ppc_pkg::S_MUL0:  state_next = ppc_pkg::S_MUL1;
      ppc_pkg::S_MUL1:  state_next = ppc_pkg::S_MUL2;
      ppc_pkg::S_MUL2:  state_next = ppc_pkg::S_ACC;
      ppc_pkg::S_ACC:   state_next = ppc_pkg::S_STORE;
      ppc_pkg::S_STORE: state_next = status.last ? ppc_pkg::S_FINAL : ppc_pkg::S_IDLE;
      ppc_pkg::S_FINAL: state_next = status.single ? ppc_pkg::S_SINGLE : ppc_pkg::S_RD0;
      ppc_pkg::S_SINGLE: begin
        if (status.out_free) begin
          state_next = ppc_pkg::S_CLEAR;
        end
      end
      ppc_pkg::S_CLEAR: state_next = ppc_pkg::S_IDLE;
      ppc_pkg::S_RD0:   state_next = ppc_pkg::S_RD0W;
      ppc_pkg::S_RD0W:  state_next = ppc_pkg::S_RDN;
      ppc_pkg::S_RDN:   state_next = ppc_pkg::S_RDNW;
      ppc_pkg::S_RDNW:  state_next = ppc_pkg::S_EV;
      ppc_pkg::S_EV: begin
        if (!status.emit_v || status.out_free) begin
          state_next = status.edge_cut ? ppc_pkg::S_CG : ppc_pkg::S_ADV;
        end
      end
      ppc_pkg::S_CG:    state_next = ppc_pkg::S_CW;
      ppc_pkg::S_CW: begin
        if (status.cut_done) begin
          state_next = status.cut_last ? ppc_pkg::S_EC : ppc_pkg::S_CG;
        end
      end
      ppc_pkg::S_EC: begin
        if (status.out_free) begin
          state_next = ppc_pkg::S_ADV;
        end
      end
      ppc_pkg::S_ADV:   state_next = status.wrap ? ppc_pkg::S_CLEAR : ppc_pkg::S_RDN;
      default:          state_next = ppc_pkg::S_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ppc_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ppc_pkg::S_OVF:   cmd.set_ovf = 1'b1;
      ppc_pkg::S_MUL0: begin
        cmd.acc_init = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = ppc_pkg::SEL_X;
      end
      ppc_pkg::S_MUL1: begin
        cmd.acc_add = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = ppc_pkg::SEL_Y;
      end
      ppc_pkg::S_MUL2: begin
        cmd.acc_add = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = ppc_pkg::SEL_Z;
      end
      ppc_pkg::S_ACC:    cmd.acc_add = 1'b1;
      ppc_pkg::S_STORE:  cmd.store = 1'b1;
      ppc_pkg::S_SINGLE: cmd.emit_single = status.out_free;
      ppc_pkg::S_CLEAR:  cmd.clear = 1'b1;
      ppc_pkg::S_RD0:    cmd.rd_first = 1'b1;
      ppc_pkg::S_RD0W:   cmd.load_first = 1'b1;
      ppc_pkg::S_RDN:    cmd.rd_next = 1'b1;
      ppc_pkg::S_RDNW:   cmd.load_next = 1'b1;
      ppc_pkg::S_EV:     cmd.emit_vertex = status.emit_v && status.out_free;
      ppc_pkg::S_CG:     cmd.cut_start = 1'b1;
      ppc_pkg::S_CW:     cmd.cut_save = status.cut_done;
      ppc_pkg::S_EC:     cmd.emit_cut = status.out_free;
      ppc_pkg::S_ADV:    cmd.advance = !status.wrap;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- design/polygon_plane_clipper_top.sv -----
// Polygon plane clipper. Each vertex is accepted from idle, then passes the multiply,
// accumulate and store states before ready returns; the last vertex then starts the
// emit walk over the stored vertices, and each cut edge runs the shared bit-serial
// divider in the cut unit once per coordinate. Discard and overflow give one result.
// Reset is synchronous, active high: control state clears, tolerance reads 655.
module polygon_plane_clipper_top #(
  parameter int MAX_VERTICES = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ppc_pkg::TOL_W-1:0]           cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [31:0]                  vertex_x,
  input  logic signed [31:0]                  vertex_y,
  input  logic signed [31:0]                  vertex_z,
  input  logic signed [31:0]                  normal_x,
  input  logic signed [31:0]                  normal_y,
  input  logic signed [31:0]                  normal_z,
  input  logic signed [31:0]                  plane_offset,
  input  logic                                keep_front,
  input  logic                                last_vertex,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          clip_status,
  output logic signed [31:0]                  out_x,
  output logic signed [31:0]                  out_y,
  output logic signed [31:0]                  out_z,
  output logic                                is_cut_point,
  output logic                                last_result
);

  ppc_pkg::cmd_t    cmd;
  ppc_pkg::status_t status;

  ppc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ppc_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .vertex_x     (vertex_x),
    .vertex_y     (vertex_y),
    .vertex_z     (vertex_z),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .normal_z     (normal_z),
    .plane_offset (plane_offset),
    .keep_front   (keep_front),
    .last_vertex  (last_vertex),
    .cmd          (cmd),
    .status       (status),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .clip_status  (clip_status),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_z        (out_z),
    .is_cut_point (is_cut_point),
    .last_result  (last_result)
  );

endmodule

// ----- dv/polygon_plane_clipper_checker.sv -----
// Checker for the polygon plane clipper: watches the vertex, result and
// tolerance ports, predicts every result and compares it field by field.
// Depends on ppc_pkg for the class and status codes.
module polygon_plane_clipper_checker #(
  parameter int MAX_VERTICES = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [ppc_pkg::TOL_W-1:0] cfg_wdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] vertex_x,
  input  logic signed [31:0] vertex_y,
  input  logic signed [31:0] vertex_z,
  input  logic signed [31:0] normal_x,
  input  logic signed [31:0] normal_y,
  input  logic signed [31:0] normal_z,
  input  logic signed [31:0] plane_offset,
  input  logic               keep_front,
  input  logic               last_vertex,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         clip_status,
  input  logic signed [31:0] out_x,
  input  logic signed [31:0] out_y,
  input  logic signed [31:0] out_z,
  input  logic               is_cut_point,
  input  logic               last_result,
  output int                 error_count,
  output int                 pending_count,
  output int                 polygon_count,
  output int                 cut_count,
  output int                 clipped_polygons
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        cut;
    logic        last;
  } clip_result_t;

  clip_result_t expected_results[$];

  // Model copy of the polygon being loaded.
  logic signed [31:0] poly_x[MAX_VERTICES];
  logic signed [31:0] poly_y[MAX_VERTICES];
  logic signed [31:0] poly_z[MAX_VERTICES];
  logic signed [63:0] poly_dist[MAX_VERTICES];
  logic [1:0]         poly_cls[MAX_VERTICES];
  int                 poly_len;
  bit                 removed_seen;
  bit                 kept_seen;
  bit                 too_many;
  logic signed [31:0] plane_nx, plane_ny, plane_nz, plane_off;
  bit                 plane_keep_front;
  int                 tolerance;

  assign pending_count = expected_results.size();

  // Point on the edge o..p2 at fraction num/den, quotient truncated toward zero.
  function automatic logic [31:0] edge_point(logic signed [31:0] o, logic signed [31:0] p2,
                                             logic signed [63:0] num,
                                             logic signed [63:0] den);
    logic signed [63:0] so, delta, sum;
    logic [127:0] mag_delta, mag_num, mag_den, quot;
    so = o;
    delta = 64'(p2) - so;
    mag_delta = 128'(delta < 0 ? -delta : delta);
    mag_num = 128'(num < 0 ? -num : num);
    mag_den = 128'(den < 0 ? -den : den);
    quot = (mag_delta * mag_num) / mag_den;
    sum = (delta < 0) ? so - $signed(quot[63:0]) : so + $signed(quot[63:0]);
    return sum[31:0];
  endfunction

  function automatic void add_result(logic [1:0] st, logic [31:0] x, logic [31:0] y,
                                     logic [31:0] z, logic cut, ref int produced);
    clip_result_t r;
    if (produced >= ppc_pkg::RESULT_LIMIT) return;
    r.status = st;
    r.x = x;
    r.y = y;
    r.z = z;
    r.cut = cut;
    r.last = 1'b0;
    expected_results.push_back(r);
    produced++;
  endfunction

  // Take one vertex request and queue whatever results it causes.
  function automatic void clip_vertex();
    logic signed [63:0] d, num;
    logic [1:0] cls, kept_cls, removed_cls, ci, cj;
    int produced, j;
    produced = 0;
    if (poly_len == 0 && !too_many) begin
      plane_nx = normal_x;
      plane_ny = normal_y;
      plane_nz = normal_z;
      plane_off = plane_offset;
      plane_keep_front = keep_front;
    end
    kept_cls = plane_keep_front ? ppc_pkg::CLS_FRONT : ppc_pkg::CLS_BACK;
    removed_cls = plane_keep_front ? ppc_pkg::CLS_BACK : ppc_pkg::CLS_FRONT;
    if (poly_len >= MAX_VERTICES) begin
      too_many = 1'b1;
    end else begin
      d = ((64'(plane_nx) * 64'(vertex_x)) >>> 30) + ((64'(plane_ny) * 64'(vertex_y)) >>> 30)
          + ((64'(plane_nz) * 64'(vertex_z)) >>> 30) - 64'(plane_off);
      cls = (d > tolerance) ? ppc_pkg::CLS_FRONT
                            : ((d < -tolerance) ? ppc_pkg::CLS_BACK : ppc_pkg::CLS_ON);
      poly_x[poly_len] = vertex_x;
      poly_y[poly_len] = vertex_y;
      poly_z[poly_len] = vertex_z;
      poly_dist[poly_len] = d;
      poly_cls[poly_len] = cls;
      if (cls == kept_cls) kept_seen = 1'b1;
      else if (cls != ppc_pkg::CLS_ON) removed_seen = 1'b1;
      poly_len++;
    end
    if (!last_vertex) return;

    polygon_count++;
    if (too_many) begin
      add_result(ppc_pkg::ST_OVERFLOW, '0, '0, '0, 1'b0, produced);
    end else if (!removed_seen) begin
      for (int i = 0; i < poly_len; i++)
        add_result(ppc_pkg::ST_WHOLE, poly_x[i], poly_y[i], poly_z[i], 1'b0, produced);
    end else if (!kept_seen) begin
      add_result(ppc_pkg::ST_DISCARD, '0, '0, '0, 1'b0, produced);
    end else begin
      clipped_polygons++;
      for (int i = 0; i < poly_len; i++) begin
        j = (i + 1 < poly_len) ? i + 1 : 0;
        ci = poly_cls[i];
        cj = poly_cls[j];
        if (ci != removed_cls)
          add_result(ppc_pkg::ST_CLIPPED, poly_x[i], poly_y[i], poly_z[i], 1'b0, produced);
        if ((ci == kept_cls && cj == removed_cls) || (ci == removed_cls && cj == kept_cls)) begin
          num = poly_dist[i];
          cut_count++;
          add_result(ppc_pkg::ST_CLIPPED,
                     edge_point(poly_x[i], poly_x[j], num, num - poly_dist[j]),
                     edge_point(poly_y[i], poly_y[j], num, num - poly_dist[j]),
                     edge_point(poly_z[i], poly_z[j], num, num - poly_dist[j]), 1'b1,
                     produced);
        end
      end
    end
    if (produced > 0) expected_results[$].last = 1'b1;
    poly_len = 0;
    removed_seen = 1'b0;
    kept_seen = 1'b0;
    too_many = 1'b0;
    plane_keep_front = 1'b0;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %h actual %h", $realtime, name, exp_val, act_val);
      error_count++;
    end
  endtask

  // Sample all channels at the clock edge.
  always @(posedge clk) begin
    clip_result_t exp_r;
    if (rst) begin
      tolerance = ppc_pkg::TOL_RESET;
      poly_len = 0;
      removed_seen = 1'b0;
      kept_seen = 1'b0;
      too_many = 1'b0;
      plane_keep_front = 1'b0;
      expected_results.delete();
    end else begin
      if (cfg_we) tolerance = cfg_wdata;
      if (in_valid && in_ready) clip_vertex();
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual status %h x %h", $realtime,
                   clip_status, out_x);
          error_count++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("clip_status", 32'(exp_r.status), 32'(clip_status));
          check_field("out_x", exp_r.x, out_x);
          check_field("out_y", exp_r.y, out_y);
          check_field("out_z", exp_r.z, out_z);
          check_field("is_cut_point", 32'(exp_r.cut), 32'(is_cut_point));
          check_field("last_result", 32'(exp_r.last), 32'(last_result));
        end
      end
    end
  end

  initial begin
    error_count = 0;
    polygon_count = 0;
    cut_count = 0;
    clipped_polygons = 0;
  end

endmodule

// ----- dv/polygon_plane_clipper_top_tb.sv -----
// Top of the polygon plane clipper testbench: clock, reset, vertex stimulus,
// result back-pressure and tolerance writes. Depends on ppc_pkg, the block
// and polygon_plane_clipper_checker, which does all prediction and comparison.
module polygon_plane_clipper_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_VERTICES = 16;
  localparam int UNIT_NORMAL = 32'sh4000_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [ppc_pkg::TOL_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] vertex_x = '0, vertex_y = '0, vertex_z = '0;
  logic signed [31:0] normal_x = '0, normal_y = '0, normal_z = '0, plane_offset = '0;
  logic keep_front = 1'b0;
  logic last_vertex = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] clip_status;
  logic signed [31:0] out_x, out_y, out_z;
  logic is_cut_point, last_result;

  int error_count, pending_count, polygon_count, cut_count, clipped_polygons;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int vertices_sent = 0;

  // Current plane for the polygon being sent.
  logic signed [31:0] cur_nx, cur_ny, cur_nz, cur_off;
  logic cur_keep;

  polygon_plane_clipper_top #(.MAX_VERTICES(MAX_VERTICES)) i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_z(vertex_z),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .plane_offset(plane_offset), .keep_front(keep_front), .last_vertex(last_vertex),
    .out_valid(out_valid), .out_ready(out_ready), .clip_status(clip_status),
    .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .is_cut_point(is_cut_point), .last_result(last_result)
  );

  polygon_plane_clipper_checker #(.MAX_VERTICES(MAX_VERTICES)) i_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_z(vertex_z),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .plane_offset(plane_offset), .keep_front(keep_front), .last_vertex(last_vertex),
    .out_valid(out_valid), .out_ready(out_ready), .clip_status(clip_status),
    .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .is_cut_point(is_cut_point), .last_result(last_result),
    .error_count(error_count), .pending_count(pending_count),
    .polygon_count(polygon_count), .cut_count(cut_count),
    .clipped_polygons(clipped_polygons)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result back-pressure.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Send one vertex request and hold it until it is accepted.
  task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z, logic last);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    vertex_x <= x;
    vertex_y <= y;
    vertex_z <= z;
    normal_x <= cur_nx;
    normal_y <= cur_ny;
    normal_z <= cur_nz;
    plane_offset <= cur_off;
    keep_front <= cur_keep;
    last_vertex <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    vertices_sent++;
  endtask

  task automatic set_plane(logic signed [31:0] nx, logic signed [31:0] ny,
                           logic signed [31:0] nz, logic signed [31:0] off, logic keep);
    cur_nx = nx;
    cur_ny = ny;
    cur_nz = nz;
    cur_off = off;
    cur_keep = keep;
  endtask

  function automatic logic signed [31:0] rand_normal();
    return $signed(32'($urandom_range(32'h8000_0000, 0))) - UNIT_NORMAL;
  endfunction

  function automatic logic signed [31:0] rand_coord(int unsigned span);
    return $signed(32'($urandom_range(2 * span, 0))) - $signed(32'(span));
  endfunction

  // One random polygon: mostly small, well-formed ones around the plane,
  // now and then full-range noise or an oversized vertex list.
  task automatic send_polygon();
    int n, kind, axis;
    int unsigned span;
    kind = $urandom_range(99);
    if (kind < 4) n = $urandom_range(MAX_VERTICES + 3, MAX_VERTICES - 1);
    else if (kind < 10) n = $urandom_range(MAX_VERTICES, 9);
    else n = $urandom_range(8, 1);
    axis = $urandom_range(3);
    case (axis)
      0: set_plane($urandom_range(1) ? UNIT_NORMAL : -UNIT_NORMAL, 0, 0, 0, 1'b0);
      1: set_plane(0, $urandom_range(1) ? UNIT_NORMAL : -UNIT_NORMAL, 0, 0, 1'b0);
      2: set_plane(0, 0, $urandom_range(1) ? UNIT_NORMAL : -UNIT_NORMAL, 0, 1'b0);
      default: set_plane(rand_normal(), rand_normal(), rand_normal(), 0, 1'b0);
    endcase
    cur_keep = 1'($urandom_range(1));
    span = (kind >= 90) ? 32'h7FFF_FFFF : (32'h1 << $urandom_range(24, 8));
    cur_off = (kind >= 90) ? $signed($urandom()) : rand_coord(span / 2);
    for (int i = 0; i < n; i++) begin
      if (kind >= 90)
        send_vertex($signed($urandom()), $signed($urandom()), $signed($urandom()), i == n - 1);
      else
        send_vertex(rand_coord(span), rand_coord(span), rand_coord(span), i == n - 1);
    end
  endtask

  // Let the block drain and return to idle, then write the tolerance.
  task automatic write_tolerance(logic [ppc_pkg::TOL_W-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    while (!in_ready) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int gap, int stall, int item_goal);
    int start;
    send_gap_pct = gap;
    recv_stall_pct = stall;
    start = vertices_sent;
    while (vertices_sent - start < item_goal) send_polygon();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Crossing triangle with extreme coordinates, keep front.
    set_plane(UNIT_NORMAL, 0, 0, 0, 1'b1);
    send_vertex(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
    send_vertex(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
    send_vertex(0, 32'sh0001_0000, 0, 1'b1);
    // Every vertex on the plane gives the polygon back whole.
    set_plane(0, 0, -UNIT_NORMAL, 0, 1'b0);
    send_vertex(32'sh0010_0000, 0, 0, 1'b0);
    send_vertex(0, -32'sh0010_0000, 0, 1'b0);
    send_vertex(-32'sh0010_0000, 32'sh0003_0000, 0, 1'b1);
    // A single vertex that is both first and last.
    set_plane(0, -UNIT_NORMAL, 0, 32'sh7FFF_FFFF, 1'b1);
    send_vertex(0, 0, 0, 1'b1);
    // Nothing on the kept side gives one discarded result.
    set_plane(0, UNIT_NORMAL, 0, 32'sh8000_0000, 1'b0);
    send_vertex(1, 2, 3, 1'b0);
    send_vertex(-1, 32'sh0100_0000, 5, 1'b0);
    send_vertex(7, 32'sh7FFF_FFFF, 9, 1'b1);
    // One vertex too many gives an overflow.
    set_plane(UNIT_NORMAL, 0, 0, 0, 1'b0);
    for (int i = 0; i <= MAX_VERTICES; i++)
      send_vertex(rand_coord(32'h10_0000), 0, 0, i == MAX_VERTICES);

    write_tolerance('0);
    random_phase(36, 80, 100);
    write_tolerance(16'hFFFF);
    random_phase(80, 36, 100);
    write_tolerance(16'($urandom()));
    random_phase(0, 0, 60);
    write_tolerance(ppc_pkg::TOL_RESET);
    random_phase(0, 0, 30);

    // Drain everything still in flight.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Sent %0d vertices in %0d polygons over four tolerance settings,",
             vertices_sent, polygon_count);
    $display("with %0d clipped polygons and %0d cut points checked.",
             clipped_polygons, cut_count);
    if (error_count == 0) begin
      $display("polygon_plane_clipper_top_tb passed");
    end else begin
      $display("polygon_plane_clipper_top_tb failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #6_000_000;
    $display("Timeout with %0d results outstanding.", pending_count);
    $display("polygon_plane_clipper_top_tb failed");
    $finish;
  end

endmodule
